[hdl/qcc_pkg.sv]
// qcc_pkg: shared constants, types and helper functions of the quality covariate counter
`timescale 1ns / 1ps

package qcc_pkg;

    // table geometry
    localparam int QUAL_ROWS         = 64;
    localparam int CYCLE_SLOTS       = 128;
    localparam int NUM_DINUC_CLASSES = 17;
    localparam int COUNT_WIDTH       = 32;

    localparam int QROW_W    = $clog2(QUAL_ROWS);
    localparam int Q_DEPTH   = QUAL_ROWS;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int QC_DEPTH  = QUAL_ROWS * CYCLE_SLOTS;
    localparam int QC_AW     = $clog2(QC_DEPTH);
    localparam int DN_DEPTH  = QUAL_ROWS * NUM_DINUC_CLASSES;
    localparam int DN_AW     = $clog2(DN_DEPTH);
    localparam int CLR_DEPTH = (QC_DEPTH > DN_DEPTH) ? QC_DEPTH : DN_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int WORD_W    = 2 * COUNT_WIDTH;
    localparam int SUM_W     = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

    // item kinds
    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // readback table select codes
    localparam logic [1:0] TBL_TOTAL   = 2'd0;
    localparam logic [1:0] TBL_QUAL    = 2'd1;
    localparam logic [1:0] TBL_QCYCLE  = 2'd2;
    localparam logic [1:0] TBL_QDINUC  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_COUNTED   = 3'd0;
    localparam logic [2:0] ST_FILTERED  = 3'd1;
    localparam logic [2:0] ST_BAD_QUAL  = 3'd2;
    localparam logic [2:0] ST_BAD_CYCLE = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_QUAL      = 3'd0;
    localparam logic [2:0] CFG_MIN_STAT_QUAL = 3'd1;
    localparam logic [2:0] CFG_SKIP_N        = 3'd2;
    localparam logic [2:0] CFG_SMOOTH_MISS   = 3'd3;
    localparam logic [2:0] CFG_SMOOTH_BASES  = 3'd4;

    // ascii base codes
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_N = 8'h4E;

    localparam logic [4:0] DINUC_NONE = 5'd16;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    // controller to datapath commands
    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_en;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
    } t_sts;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    // base code over the order A,G,C,T; bit 2 flags a known base
    function automatic logic [2:0] nuc_code(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            CH_A:    code = 3'b100;
            CH_G:    code = 3'b101;
            CH_C:    code = 3'b110;
            CH_T:    code = 3'b111;
            default: code = 3'b000;
        endcase
        return code;
    endfunction

    // saturating increment
    function automatic t_cnt cnt_inc(input t_cnt cnt);
        t_cnt res;
        res = (cnt == {COUNT_WIDTH{1'b1}}) ? cnt : cnt + t_cnt'(1);
        return res;
    endfunction

    // counter plus smoothing, clamped to counter maximum and then to 32 bits
    function automatic logic [31:0] sat_out(input t_cnt cnt, input logic [15:0] add);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] lim;
        logic [SUM_W-1:0] out_lim;
        sum     = SUM_W'(cnt) + SUM_W'(add);
        lim     = SUM_W'({COUNT_WIDTH{1'b1}});
        out_lim = SUM_W'({32{1'b1}});
        if (sum > lim) begin
            sum = lim;
        end
        if (sum > out_lim) begin
            sum = out_lim;
        end
        return 32'(sum);
    endfunction

endpackage

[hdl/qcc_ram.sv]
// qcc_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module qcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/qcc_datapath.sv]
// qcc_datapath: config registers, item decode, counter tables and result register
`timescale 1ns / 1ps

module qcc_datapath
    import qcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_kind,
    input  logic [7:0]  i_read_base,
    input  logic [7:0]  i_ref_base,
    input  logic [7:0]  i_quality,
    input  logic [6:0]  i_cycle,
    input  logic        i_first_in_read,
    input  logic [1:0]  i_table_select,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_column,
    output logic [2:0]  o_status,
    output logic        o_mismatch,
    output logic [4:0]  o_dinuc_class,
    output logic [31:0] o_miss_count,
    output logic [31:0] o_base_count
);

    // configuration registers
    logic [7:0]  r_q_offset;
    logic [7:0]  r_min_stat;
    logic        r_skip_n;
    logic [15:0] r_smooth_miss;
    logic [15:0] r_smooth_bases;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_offset     <= '0;
            r_min_stat     <= '0;
            r_skip_n       <= 1'b1;
            r_smooth_miss  <= '0;
            r_smooth_bases <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_QUAL:      r_q_offset     <= i_cfg_data[7:0];
                CFG_MIN_STAT_QUAL: r_min_stat     <= i_cfg_data[7:0];
                CFG_SKIP_N:        r_skip_n       <= i_cfg_data[0];
                CFG_SMOOTH_MISS:   r_smooth_miss  <= i_cfg_data;
                CFG_SMOOTH_BASES:  r_smooth_bases <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clearing sweep counter
    logic [CLR_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= r_clr_cnt + CLR_W'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == CLR_W'(CLR_DEPTH - 1));

    // decode of the incoming beat
    logic [7:0]        r_prev_base;
    logic [2:0]        w_nuc_a;
    logic [2:0]        w_nuc_b;
    logic [4:0]        w_dinuc;
    logic              w_miss;
    logic signed [9:0] w_qm1;
    logic signed [9:0] w_qrow;
    logic              w_filtered;
    logic              w_bad_qual;
    logic              w_bad_cycle;
    logic [QROW_W-1:0] w_row;
    logic [6:0]        w_col;
    logic [6:0]        w_dcol;
    logic              w_row_bad;
    logic [2:0]        w_status;

    always_comb begin
        w_nuc_a = nuc_code(r_prev_base);
        w_nuc_b = nuc_code(i_read_base);
        w_dinuc = (!i_first_in_read && w_nuc_a[2] && w_nuc_b[2])
                  ? {1'b0, w_nuc_a[1:0], w_nuc_b[1:0]} : DINUC_NONE;
        w_miss  = (i_read_base != i_ref_base);

        w_qm1  = $signed({2'b00, i_quality}) - 10'sd1;
        w_qrow = $signed({2'b00, i_quality}) - $signed({2'b00, r_q_offset}) - 10'sd1;
        w_filtered  = (r_skip_n && (i_read_base == CH_N))
                      || (w_qm1 < $signed({2'b00, r_min_stat}));
        w_bad_qual  = w_qrow[9] || (w_qrow[8:0] >= 9'(QUAL_ROWS));
        w_bad_cycle = (11'(i_cycle) >= 11'(CYCLE_SLOTS));
        w_row_bad   = (9'(i_read_row) >= 9'(QUAL_ROWS));

        if (i_kind == KIND_COUNT) begin
            w_row  = w_qrow[QROW_W-1:0];
            w_col  = i_cycle;
            w_dcol = {2'b00, w_dinuc};
            if (w_filtered) begin
                w_status = ST_FILTERED;
            end else if (w_bad_qual) begin
                w_status = ST_BAD_QUAL;
            end else if (w_bad_cycle) begin
                w_status = ST_BAD_CYCLE;
            end else begin
                w_status = ST_COUNTED;
            end
        end else begin
            w_row  = i_read_row[QROW_W-1:0];
            w_col  = i_read_column;
            w_dcol = i_read_column;
            case (i_table_select)
                TBL_TOTAL:  w_status = ST_READ_OK;
                TBL_QUAL:   w_status = w_row_bad ? ST_BAD_ADDR : ST_READ_OK;
                TBL_QCYCLE: w_status = (w_row_bad || (11'(i_read_column) >= 11'(CYCLE_SLOTS)))
                                       ? ST_BAD_ADDR : ST_READ_OK;
                TBL_QDINUC: w_status = (w_row_bad
                                        || (11'(i_read_column) >= 11'(NUM_DINUC_CLASSES)))
                                       ? ST_BAD_ADDR : ST_READ_OK;
                default:    w_status = ST_BAD_ADDR;
            endcase
        end
    end

    // registered item context
    logic             r_kind;
    logic [1:0]       r_sel;
    logic [2:0]       r_status;
    logic             r_miss;
    logic [4:0]       r_dinuc;
    logic [Q_AW-1:0]  r_q_addr;
    logic [QC_AW-1:0] r_qc_addr;
    logic [DN_AW-1:0] r_dn_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_base <= '0;
        end else if (i_cmd.load && (i_kind == KIND_COUNT)) begin
            r_prev_base <= i_read_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_sel     <= i_table_select;
            r_status  <= w_status;
            r_miss    <= (i_kind == KIND_COUNT) ? w_miss : 1'b0;
            r_dinuc   <= (i_kind == KIND_COUNT) ? w_dinuc : DINUC_NONE;
            r_q_addr  <= Q_AW'(w_row);
            r_qc_addr <= QC_AW'(w_row) * QC_AW'(CYCLE_SLOTS) + QC_AW'(w_col);
            r_dn_addr <= DN_AW'(w_row) * DN_AW'(NUM_DINUC_CLASSES) + DN_AW'(w_dcol);
        end
    end

    // counter tables
    logic [WORD_W-1:0] w_q_rdata;
    logic [WORD_W-1:0] w_qc_rdata;
    logic [WORD_W-1:0] w_dn_rdata;
    logic [WORD_W-1:0] w_q_wdata;
    logic [WORD_W-1:0] w_qc_wdata;
    logic [WORD_W-1:0] w_dn_wdata;
    logic              w_upd;
    logic              w_q_we;
    logic              w_qc_we;
    logic              w_dn_we;
    logic [Q_AW-1:0]   w_q_waddr;
    logic [QC_AW-1:0]  w_qc_waddr;
    logic [DN_AW-1:0]  w_dn_waddr;

    // bump a packed {bases, misses} word
    function automatic logic [WORD_W-1:0] word_bump(input logic [WORD_W-1:0] word,
                                                     input logic miss);
        t_cnt mc;
        t_cnt bc;
        mc = word[COUNT_WIDTH-1:0];
        bc = word[WORD_W-1:COUNT_WIDTH];
        return {cnt_inc(bc), miss ? cnt_inc(mc) : mc};
    endfunction

    always_comb begin
        w_upd = i_cmd.commit && (r_kind == KIND_COUNT) && (r_status == ST_COUNTED);
        if (i_cmd.clr_en) begin
            w_q_we     = ({1'b0, r_clr_cnt} < (CLR_W + 1)'(Q_DEPTH));
            w_qc_we    = ({1'b0, r_clr_cnt} < (CLR_W + 1)'(QC_DEPTH));
            w_dn_we    = ({1'b0, r_clr_cnt} < (CLR_W + 1)'(DN_DEPTH));
            w_q_waddr  = r_clr_cnt[Q_AW-1:0];
            w_qc_waddr = r_clr_cnt[QC_AW-1:0];
            w_dn_waddr = r_clr_cnt[DN_AW-1:0];
            w_q_wdata  = '0;
            w_qc_wdata = '0;
            w_dn_wdata = '0;
        end else begin
            w_q_we     = w_upd;
            w_qc_we    = w_upd;
            w_dn_we    = w_upd;
            w_q_waddr  = r_q_addr;
            w_qc_waddr = r_qc_addr;
            w_dn_waddr = r_dn_addr;
            w_q_wdata  = word_bump(w_q_rdata, r_miss);
            w_qc_wdata = word_bump(w_qc_rdata, r_miss);
            w_dn_wdata = word_bump(w_dn_rdata, r_miss);
        end
    end

    qcc_ram #(.WIDTH(WORD_W), .DEPTH(Q_DEPTH)) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_q_addr),
        .o_rdata (w_q_rdata)
    );

    qcc_ram #(.WIDTH(WORD_W), .DEPTH(QC_DEPTH)) u_qc_ram (
        .i_clk   (i_clk),
        .i_we    (w_qc_we),
        .i_waddr (w_qc_waddr),
        .i_wdata (w_qc_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_qc_addr),
        .o_rdata (w_qc_rdata)
    );

    qcc_ram #(.WIDTH(WORD_W), .DEPTH(DN_DEPTH)) u_dn_ram (
        .i_clk   (i_clk),
        .i_we    (w_dn_we),
        .i_waddr (w_dn_waddr),
        .i_wdata (w_dn_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_dn_addr),
        .o_rdata (w_dn_rdata)
    );

    // totals
    t_cnt r_tot_miss;
    t_cnt r_tot_bases;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_miss  <= '0;
            r_tot_bases <= '0;
        end else if (w_upd) begin
            r_tot_bases <= cnt_inc(r_tot_bases);
            if (r_miss) begin
                r_tot_miss <= cnt_inc(r_tot_miss);
            end
        end
    end

    // readback pair, with smoothing on the non-total tables
    logic [31:0] w_rd_miss;
    logic [31:0] w_rd_bases;

    always_comb begin
        w_rd_miss  = '0;
        w_rd_bases = '0;
        if ((r_kind == KIND_READ) && (r_status == ST_READ_OK)) begin
            case (r_sel)
                TBL_TOTAL: begin
                    w_rd_miss  = sat_out(r_tot_miss, 16'd0);
                    w_rd_bases = sat_out(r_tot_bases, 16'd0);
                end
                TBL_QUAL: begin
                    w_rd_miss  = sat_out(w_q_rdata[COUNT_WIDTH-1:0], r_smooth_miss);
                    w_rd_bases = sat_out(w_q_rdata[WORD_W-1:COUNT_WIDTH], r_smooth_bases);
                end
                TBL_QCYCLE: begin
                    w_rd_miss  = sat_out(w_qc_rdata[COUNT_WIDTH-1:0], r_smooth_miss);
                    w_rd_bases = sat_out(w_qc_rdata[WORD_W-1:COUNT_WIDTH], r_smooth_bases);
                end
                default: begin
                    w_rd_miss  = sat_out(w_dn_rdata[COUNT_WIDTH-1:0], r_smooth_miss);
                    w_rd_bases = sat_out(w_dn_rdata[WORD_W-1:COUNT_WIDTH], r_smooth_bases);
                end
            endcase
        end
    end

    // result register
    logic [2:0]  r_out_status;
    logic        r_out_miss;
    logic [4:0]  r_out_dinuc;
    logic [31:0] r_out_miss_cnt;
    logic [31:0] r_out_base_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status   <= r_status;
            r_out_miss     <= r_miss;
            r_out_dinuc    <= r_dinuc;
            r_out_miss_cnt <= w_rd_miss;
            r_out_base_cnt <= w_rd_bases;
        end
    end

    assign o_status      = r_out_status;
    assign o_mismatch    = r_out_miss;
    assign o_dinuc_class = r_out_dinuc;
    assign o_miss_count  = r_out_miss_cnt;
    assign o_base_count  = r_out_base_cnt;

endmodule

[hdl/qcc_ctrl.sv]
// qcc_ctrl: state machine sequencing clearing, lookup and commit of each beat
`timescale 1ns / 1ps

module qcc_ctrl
    import qcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   w_cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                w_cmd.rd_en = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                if (!r_out_valid || i_ready) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // output beat holding
    always_comb begin
        if (w_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

    // no beat is taken during the clearing sweep
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("input beat accepted during clearing sweep");

    // an accepted beat always goes to the table lookup
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_READ))
        else $error("accepted beat did not start a lookup");

    // commit never overwrites an untaken result
    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!r_out_valid || i_ready))
        else $error("commit overwrote a pending result");

    // a commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_valid)
        else $error("commit without output beat");

    // sweep ends in idle
    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_sts.clr_last) |=> (r_state == S_IDLE))
        else $error("clearing sweep did not end in idle");

endmodule

[hdl/quality_covariate_counter_top.sv]
// quality_covariate_counter_top: top level of the base quality covariate counter
`timescale 1ns / 1ps

// Counts sequenced bases into saturating miss/base counter pairs over four tables (totals,
// quality, quality by cycle, quality by dinucleotide) and reads back one pair per readback
// beat, with smoothing added to the non-total tables. After reset the block runs a clearing
// pass over the counter RAMs, one entry per cycle, with input ready held low;
// configuration writes are taken during it. Each beat then passes through accept and
// decode, RAM read, and read-modify-write with result load, in that order, as set by the
// single registered read port of the counter RAMs. One beat is in flight at a time, and
// a new beat is accepted while the previous result still waits in the output register;
// the new beat then holds in its last step until that result is taken.

module quality_covariate_counter_top
    import qcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_read_base,
    input  logic [7:0]  i_ref_base,
    input  logic [7:0]  i_quality,
    input  logic [6:0]  i_cycle,
    input  logic        i_first_in_read,
    input  logic [1:0]  i_table_select,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_column,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_mismatch,
    output logic [4:0]  o_dinuc_class,
    output logic [31:0] o_miss_count,
    output logic [31:0] o_base_count
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing
    qcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // tables and result path
    qcc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (i_kind),
        .i_read_base     (i_read_base),
        .i_ref_base      (i_ref_base),
        .i_quality       (i_quality),
        .i_cycle         (i_cycle),
        .i_first_in_read (i_first_in_read),
        .i_table_select  (i_table_select),
        .i_read_row      (i_read_row),
        .i_read_column   (i_read_column),
        .o_status        (o_status),
        .o_mismatch      (o_mismatch),
        .o_dinuc_class   (o_dinuc_class),
        .o_miss_count    (o_miss_count),
        .o_base_count    (o_base_count)
    );

endmodule

[verif/qcc_tally_checker.sv]
// qcc_tally_checker: predicts every result beat of the quality covariate counter and checks it
`timescale 1ns / 1ps

module qcc_tally_checker
    import qcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_base_valid,
    input  logic        i_base_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_read_base,
    input  logic [7:0]  i_ref_base,
    input  logic [7:0]  i_quality,
    input  logic [6:0]  i_cycle,
    input  logic        i_first_in_read,
    input  logic [1:0]  i_table_select,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_column,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_status,
    input  logic        i_mismatch,
    input  logic [4:0]  i_dinuc_class,
    input  logic [31:0] i_miss_count,
    input  logic [31:0] i_base_count,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic        mismatch;
        logic [4:0]  dinuc;
        logic [31:0] misses;
        logic [31:0] bases;
    } t_tally;

    // mirrored registers
    logic [7:0]  q_offset;
    logic [7:0]  min_stat_qual;
    logic        skip_n;
    logic [15:0] smooth_miss;
    logic [15:0] smooth_bases;

    // mirrored counter tables
    t_cnt       tot_misses;
    t_cnt       tot_bases;
    t_cnt       row_misses  [Q_DEPTH];
    t_cnt       row_bases   [Q_DEPTH];
    t_cnt       qcyc_misses [QC_DEPTH];
    t_cnt       qcyc_bases  [QC_DEPTH];
    t_cnt       qdn_misses  [DN_DEPTH];
    t_cnt       qdn_bases   [DN_DEPTH];
    logic [7:0] prev_base;

    t_tally tally_q[$];
    int     errors = 0;

    // rank over A,G,C,T, -1 for anything else
    function automatic int base_rank(input logic [7:0] ch);
        case (ch)
            CH_A:    return 0;
            CH_G:    return 1;
            CH_C:    return 2;
            CH_T:    return 3;
            default: return -1;
        endcase
    endfunction

    function automatic t_cnt bumped(input t_cnt c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

    // counter plus smoothing, clamped to the counter range and then to 32 bits
    function automatic logic [31:0] smoothed(input t_cnt c, input logic [15:0] add);
        longint unsigned sum;
        longint unsigned cap;
        sum = longint'(c) + longint'(add);
        cap = (64'd1 << COUNT_WIDTH) - 64'd1;
        if (sum > cap) begin
            sum = cap;
        end
        if (sum > 64'hFFFF_FFFF) begin
            sum = 64'hFFFF_FFFF;
        end
        return sum[31:0];
    endfunction

    task automatic clear_model();
        q_offset      = '0;
        min_stat_qual = '0;
        skip_n        = 1'b1;
        smooth_miss   = '0;
        smooth_bases  = '0;
        tot_misses    = '0;
        tot_bases     = '0;
        prev_base     = '0;
        for (int i = 0; i < Q_DEPTH; i++) begin
            row_misses[i] = '0;
            row_bases[i]  = '0;
        end
        for (int i = 0; i < QC_DEPTH; i++) begin
            qcyc_misses[i] = '0;
            qcyc_bases[i]  = '0;
        end
        for (int i = 0; i < DN_DEPTH; i++) begin
            qdn_misses[i] = '0;
            qdn_bases[i]  = '0;
        end
    endtask

    // work out the result of one input beat and update the mirrored tables
    task automatic tally_beat(output t_tally res);
        int         a;
        int         b;
        int         qrow;
        int         ic;
        int         id;
        logic [4:0] dn;
        res       = '0;
        res.dinuc = DINUC_NONE;
        if (i_kind == KIND_COUNT) begin
            a  = base_rank(prev_base);
            b  = base_rank(i_read_base);
            dn = DINUC_NONE;
            if (!i_first_in_read && a >= 0 && b >= 0) begin
                dn = 5'(4 * a + b);
            end
            // every count beat moves the previous base, counted or not
            prev_base    = i_read_base;
            res.mismatch = (i_read_base != i_ref_base);
            res.dinuc    = dn;
            qrow = int'(i_quality) - int'(q_offset) - 1;
            if ((skip_n && i_read_base == CH_N) ||
                int'(i_quality) - 1 < int'(min_stat_qual)) begin
                res.status = ST_FILTERED;
            end else if (qrow < 0 || qrow >= QUAL_ROWS) begin
                res.status = ST_BAD_QUAL;
            end else if (int'(i_cycle) >= CYCLE_SLOTS) begin
                res.status = ST_BAD_CYCLE;
            end else begin
                ic = qrow * CYCLE_SLOTS + int'(i_cycle);
                id = qrow * NUM_DINUC_CLASSES + int'(dn);
                tot_bases       = bumped(tot_bases);
                row_bases[qrow] = bumped(row_bases[qrow]);
                qcyc_bases[ic]  = bumped(qcyc_bases[ic]);
                qdn_bases[id]   = bumped(qdn_bases[id]);
                if (res.mismatch) begin
                    tot_misses       = bumped(tot_misses);
                    row_misses[qrow] = bumped(row_misses[qrow]);
                    qcyc_misses[ic]  = bumped(qcyc_misses[ic]);
                    qdn_misses[id]   = bumped(qdn_misses[id]);
                end
                res.status = ST_COUNTED;
            end
        end else if (i_table_select == TBL_TOTAL) begin
            // totals take no smoothing and ignore the address
            res.status = ST_READ_OK;
            res.misses = smoothed(tot_misses, 16'd0);
            res.bases  = smoothed(tot_bases, 16'd0);
        end else if (int'(i_read_row) >= QUAL_ROWS) begin
            res.status = ST_BAD_ADDR;
        end else if (i_table_select == TBL_QUAL) begin
            res.status = ST_READ_OK;
            res.misses = smoothed(row_misses[i_read_row], smooth_miss);
            res.bases  = smoothed(row_bases[i_read_row], smooth_bases);
        end else if (i_table_select == TBL_QCYCLE) begin
            if (int'(i_read_column) >= CYCLE_SLOTS) begin
                res.status = ST_BAD_ADDR;
            end else begin
                ic = int'(i_read_row) * CYCLE_SLOTS + int'(i_read_column);
                res.status = ST_READ_OK;
                res.misses = smoothed(qcyc_misses[ic], smooth_miss);
                res.bases  = smoothed(qcyc_bases[ic], smooth_bases);
            end
        end else begin
            if (int'(i_read_column) >= NUM_DINUC_CLASSES) begin
                res.status = ST_BAD_ADDR;
            end else begin
                id = int'(i_read_row) * NUM_DINUC_CLASSES + int'(i_read_column);
                res.status = ST_READ_OK;
                res.misses = smoothed(qdn_misses[id], smooth_miss);
                res.bases  = smoothed(qdn_bases[id], smooth_bases);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // follow the register port and both channels
    always @(posedge i_clk) begin : watch_channels
        t_tally want;
        if (!i_rst_n) begin
            clear_model();
            tally_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_QUAL:      q_offset      = i_cfg_data[7:0];
                    CFG_MIN_STAT_QUAL: min_stat_qual = i_cfg_data[7:0];
                    CFG_SKIP_N:        skip_n        = i_cfg_data[0];
                    CFG_SMOOTH_MISS:   smooth_miss   = i_cfg_data;
                    CFG_SMOOTH_BASES:  smooth_bases  = i_cfg_data;
                    default: ;
                endcase
            end
            // result beat against the oldest prediction
            if (i_res_valid && i_res_ready) begin
                if (tally_q.size() == 0) begin
                    $display("%0t: result beat with nothing predicted, status %0d",
                             $time, i_status);
                    errors++;
                end else begin
                    want = tally_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_status));
                    compare_field("mismatch", 32'(want.mismatch), 32'(i_mismatch));
                    compare_field("dinuc_class", 32'(want.dinuc), 32'(i_dinuc_class));
                    compare_field("miss_count", want.misses, i_miss_count);
                    compare_field("base_count", want.bases, i_base_count);
                end
            end
            // input beat into the model
            if (i_base_valid && i_base_ready) begin
                tally_beat(want);
                tally_q.push_back(want);
            end
        end
        o_pending    <= tally_q.size();
        o_fail_count <= errors;
    end

endmodule

[verif/tb.sv]
// tb: clock, reset, stimulus and verdict for the quality covariate counter
`timescale 1ns / 1ps

module tb;
    import qcc_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] read_base;
        logic [7:0] ref_base;
        logic [7:0] quality;
        logic [6:0] cycle;
        logic       first;
        logic [1:0] tsel;
        logic [5:0] row;
        logic [6:0] col;
    } t_base_beat;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        base_valid;
    logic        base_ready;
    t_base_beat  beat;
    logic        res_valid;
    logic        res_ready;
    logic [2:0]  status;
    logic        mismatch;
    logic [4:0]  dinuc_class;
    logic [31:0] miss_count;
    logic [31:0] base_count;
    int          fail_count;
    int          pending;

    // knobs shared between the two sides
    bit sender_idle;
    bit receiver_idle;
    bit hold_req;
    int cur_min_q;

    always #4 clk = ~clk;

    quality_covariate_counter_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_valid         (base_valid),
        .o_ready         (base_ready),
        .i_kind          (beat.kind),
        .i_read_base     (beat.read_base),
        .i_ref_base      (beat.ref_base),
        .i_quality       (beat.quality),
        .i_cycle         (beat.cycle),
        .i_first_in_read (beat.first),
        .i_table_select  (beat.tsel),
        .i_read_row      (beat.row),
        .i_read_column   (beat.col),
        .o_valid         (res_valid),
        .i_ready         (res_ready),
        .o_status        (status),
        .o_mismatch      (mismatch),
        .o_dinuc_class   (dinuc_class),
        .o_miss_count    (miss_count),
        .o_base_count    (base_count)
    );

    qcc_tally_checker i_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_base_valid    (base_valid),
        .i_base_ready    (base_ready),
        .i_kind          (beat.kind),
        .i_read_base     (beat.read_base),
        .i_ref_base      (beat.ref_base),
        .i_quality       (beat.quality),
        .i_cycle         (beat.cycle),
        .i_first_in_read (beat.first),
        .i_table_select  (beat.tsel),
        .i_read_row      (beat.row),
        .i_read_column   (beat.col),
        .i_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .i_status        (status),
        .i_mismatch      (mismatch),
        .i_dinuc_class   (dinuc_class),
        .i_miss_count    (miss_count),
        .i_base_count    (base_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // all fields random, kind included
    function automatic t_base_beat random_beat();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic t_base_beat count_beat(input logic [7:0] rb, input logic [7:0] fb,
                                              input logic [7:0] q, input logic [6:0] cyc,
                                              input logic first);
        t_base_beat b;
        b           = random_beat();
        b.kind      = KIND_COUNT;
        b.read_base = rb;
        b.ref_base  = fb;
        b.quality   = q;
        b.cycle     = cyc;
        b.first     = first;
        return b;
    endfunction

    // address fields set, the rest left random since a readback ignores them
    function automatic t_base_beat read_beat(input logic [1:0] tsel, input logic [5:0] row,
                                             input logic [6:0] col);
        t_base_beat b;
        b      = random_beat();
        b.kind = KIND_READ;
        b.tsel = tsel;
        b.row  = row;
        b.col  = col;
        return b;
    endfunction

    // mostly real bases, some n, some arbitrary bytes
    function automatic logic [7:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 92) begin
            return 8'($urandom_range(0, 255));
        end else if (r >= 85) begin
            return CH_N;
        end
        case ($urandom_range(0, 3))
            0:       return CH_A;
            1:       return CH_G;
            2:       return CH_C;
            default: return CH_T;
        endcase
    endfunction

    // mostly inside the table window of the current offset
    function automatic logic [7:0] pick_quality();
        int q;
        q = cur_min_q + 1 + $urandom_range(0, 63);
        if (q > 255 || $urandom_range(0, 99) < 15) begin
            q = $urandom_range(0, 255);
        end
        return 8'(q);
    endfunction

    task automatic send_beat(input t_base_beat b);
        int gap;
        gap = sender_idle ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap > 0) begin
            base_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        beat       <= b;
        base_valid <= 1'b1;
        do @(posedge clk); while (!base_ready);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int mq, input int msq, input int skip, input int sm,
                             input int sb);
        cfg_write(CFG_MIN_QUAL, mq);
        cfg_write(CFG_MIN_STAT_QUAL, msq);
        cfg_write(CFG_SKIP_N, skip);
        cfg_write(CFG_SMOOTH_MISS, sm);
        cfg_write(CFG_SMOOTH_BASES, sb);
        cur_min_q = mq;
    endtask

    // idle the input and let every predicted result come back
    task automatic drain_results();
        @(negedge clk);
        base_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // mostly well-formed reads, with readbacks aimed at the rows just counted
    task automatic random_traffic(input int n_beats);
        int         sent;
        int         len;
        int         start;
        int         r;
        logic [7:0] rb;
        logic [7:0] fb;
        logic [7:0] q;
        logic [6:0] cyc;
        logic [1:0] tsel;
        sent = 0;
        while (sent < n_beats) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len   = $urandom_range(1, 40);
                start = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : 0;
                for (int i = 0; i < len; i++) begin
                    rb  = pick_base();
                    fb  = ($urandom_range(0, 9) == 0) ? pick_base() : rb;
                    q   = pick_quality();
                    cyc = 7'(start + i);
                    send_beat(count_beat(rb, fb, q, cyc, i == 0));
                    sent++;
                    if ($urandom_range(0, 9) == 0) begin
                        tsel = 2'($urandom_range(1, 3));
                        send_beat(read_beat(tsel, 6'(int'(q) - cur_min_q - 1),
                                            (tsel == TBL_QCYCLE) ? cyc :
                                            7'($urandom_range(0, 16))));
                        sent++;
                    end
                end
            end else if (r < 85) begin
                send_beat(read_beat(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                                    ($urandom_range(0, 1) == 1) ?
                                    7'($urandom_range(0, 127)) :
                                    7'($urandom_range(0, 20))));
                sent++;
            end else begin
                send_beat(random_beat());
                sent++;
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_side
        int stall;
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            stall = receiver_idle ? $urandom_range(0, 13) : 0;
            if (hold_req) begin
                res_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    // hard stop
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int mq;
        int guard;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MIN_QUAL;
        cfg_data      = '0;
        base_valid    = 1'b0;
        beat          = '0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        hold_req      = 1'b0;
        cur_min_q     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values, written while the clearing pass runs
        configure(0, 0, 1, 0, 0);

        // directed: dinucleotide pairs, filters, table edges, readback addressing
        send_beat(count_beat(CH_A, CH_A, 8'd1, 7'd0, 1'b1));     // first base, row 0
        send_beat(count_beat(CH_G, CH_A, 8'd1, 7'd127, 1'b0));   // ag, miss, last cycle
        send_beat(read_beat(TBL_TOTAL, 6'd63, 7'd127));          // keeps previous base
        send_beat(count_beat(CH_C, CH_C, 8'd64, 7'd5, 1'b0));    // gc, top row
        send_beat(count_beat(CH_T, CH_G, 8'd64, 7'd127, 1'b0));  // ct, miss
        send_beat(count_beat(CH_N, CH_N, 8'd10, 7'd1, 1'b0));    // n base filtered
        send_beat(count_beat(CH_A, CH_A, 8'd10, 7'd2, 1'b0));    // previous base unknown
        send_beat(count_beat(CH_T, CH_A, 8'd0, 7'd3, 1'b0));     // below the stat floor
        send_beat(count_beat(CH_A, CH_T, 8'd65, 7'd4, 1'b0));    // row just past the table
        send_beat(count_beat(CH_G, CH_C, 8'd255, 7'd6, 1'b0));   // top quality code
        send_beat(count_beat(8'hFF, 8'h00, 8'd20, 7'd0, 1'b1));  // odd bytes
        send_beat(count_beat(8'h00, 8'hFF, 8'd20, 7'd127, 1'b0));
        send_beat(count_beat(CH_T, CH_T, 8'd2, 7'd64, 1'b0));    // after an unknown base
        send_beat(count_beat(CH_T, CH_T, 8'd2, 7'd65, 1'b0));    // tt
        send_beat(read_beat(TBL_TOTAL, 6'd0, 7'd0));
        send_beat(read_beat(TBL_QUAL, 6'd0, 7'd127));            // column ignored
        send_beat(read_beat(TBL_QUAL, 6'd63, 7'd0));
        send_beat(read_beat(TBL_QCYCLE, 6'd0, 7'd127));
        send_beat(read_beat(TBL_QCYCLE, 6'd63, 7'd127));
        send_beat(read_beat(TBL_QDINUC, 6'd0, 7'd1));
        send_beat(read_beat(TBL_QDINUC, 6'd63, 7'd16));
        send_beat(read_beat(TBL_QDINUC, 6'd0, 7'd17));           // column out of range
        send_beat(read_beat(TBL_QDINUC, 6'd63, 7'd127));
        random_traffic(220);
        drain_results();

        // no idling, full smoothing, n counted, long output hold-off
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        configure(10, 20, 0, 16'hFFFF, 16'hFFFF);
        hold_req = 1'b1;
        random_traffic(200);
        drain_results();

        // top offsets: everything filtered or out of the table
        sender_idle = 1'b1;
        configure(255, 255, 1, 1, 0);
        random_traffic(60);
        drain_results();

        // high offset window
        sender_idle   = 1'b0;
        receiver_idle = 1'b1;
        configure(192, 0, 0, $urandom_range(0, 65535), $urandom_range(0, 65535));
        random_traffic(200);
        drain_results();

        // random setting, both sides idling, another hold-off
        sender_idle = 1'b1;
        mq = $urandom_range(0, 200);
        configure(mq, $urandom_range(0, mq + 32), $urandom_range(0, 1),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
        hold_req = 1'b1;
        random_traffic(170);

        @(negedge clk);
        base_valid <= 1'b0;
        for (guard = 0; guard < 20000 && pending != 0; guard++) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
